[hdl/mei_pkg.sv]
// Shared types, constants and the saturation helper function of the Mandelbrot escape-time iterator.
`timescale 1ns / 1ps

package mei_pkg;

    // Frame geometry; the pixel offset is taken against half the frame.
    localparam int FRAME_WIDTH  = 1024;
    localparam int FRAME_HEIGHT = 1024;

    // Field widths.
    localparam int PIX_W   = 10;
    localparam int CTR_W   = 21;
    localparam int FIX_W   = 32;
    localparam int CNT_W   = 16;
    localparam int ZOOM_W  = 32;

    // Signed pixel offset: column + centre - half frame never leaves this range.
    localparam int OFF_W   = 23;
    // Offset times zoom (zoom taken as a non-negative signed value).
    localparam int CPROD_W = OFF_W + ZOOM_W + 1;
    // Width of the wide sums before saturation.
    localparam int WIDE_W  = 66;

    // Escape bound: |z|^2 > 16 in Q.48.
    localparam logic [63:0] ESC_LIMIT = 64'h0010_0000_0000_0000;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 2;

    // Configuration register indexes (word address).
    localparam logic [2:0] REG_ZOOM       = 3'd0;
    localparam logic [2:0] REG_CENTER_X   = 3'd1;
    localparam logic [2:0] REG_CENTER_Y   = 3'd2;
    localparam logic [2:0] REG_ITER_LIMIT = 3'd3;
    localparam logic [2:0] REG_PAINT_THR  = 3'd4;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -66'sd2147483648;

    typedef struct packed {
        logic        [ZOOM_W-1:0] zoom;
        logic signed [CTR_W-1:0]  center_x;
        logic signed [CTR_W-1:0]  center_y;
        logic        [CNT_W-1:0]  iter_limit;
        logic        [CNT_W-1:0]  paint_threshold;
    } t_cfg;

    typedef struct packed {
        logic signed [FIX_W-1:0] c_re;
        logic signed [FIX_W-1:0] c_im;
    } t_cpoint;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [FIX_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [FIX_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[FIX_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[FIX_W-1:0];
        end else begin
            r = v[FIX_W-1:0];
        end
        return r;
    endfunction

endpackage

[hdl/mei_front.sv]
// Front end: accepts a pixel, forms the saturated complex point c and queues it.
`timescale 1ns / 1ps

module mei_front
    import mei_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [PIX_W-1:0]    i_column,
    input  logic [PIX_W-1:0]    i_row,
    input  t_cfg                i_cfg,
    input  t_qstat              i_qstat,
    output logic                o_qpush,
    output t_cpoint             o_qdata
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_MRE,
        F_MIM,
        F_SAT,
        F_PUSH
    } t_fstate;

    localparam logic signed [OFF_W-1:0] HALF_W = OFF_W'(FRAME_WIDTH / 2);
    localparam logic signed [OFF_W-1:0] HALF_H = OFF_W'(FRAME_HEIGHT / 2);

    t_fstate                    r_state;
    logic signed [OFF_W-1:0]    r_offx;
    logic signed [OFF_W-1:0]    r_offy;
    logic signed [CPROD_W-1:0]  r_prod;
    logic signed [FIX_W-1:0]    r_cre;
    logic signed [FIX_W-1:0]    r_cim;

    logic signed [OFF_W-1:0]    n_offx;
    logic signed [OFF_W-1:0]    n_offy;
    logic signed [OFF_W-1:0]    mul_off;
    logic signed [CPROD_W-1:0]  n_prod;
    logic signed [FIX_W-1:0]    prod_sat;

    assign n_offx = $signed({{(OFF_W-PIX_W){1'b0}}, i_column}) - HALF_W
                  + $signed({{(OFF_W-CTR_W){i_cfg.center_x[CTR_W-1]}}, i_cfg.center_x});
    assign n_offy = $signed({{(OFF_W-PIX_W){1'b0}}, i_row}) - HALF_H
                  + $signed({{(OFF_W-CTR_W){i_cfg.center_y[CTR_W-1]}}, i_cfg.center_y});

    // One multiplier, shared by the real and the imaginary part.
    assign mul_off  = (r_state == F_MRE) ? r_offx : r_offy;
    assign n_prod   = mul_off * $signed({1'b0, i_cfg.zoom});
    assign prod_sat = sat32($signed({{(WIDE_W-CPROD_W){r_prod[CPROD_W-1]}}, r_prod}));

    assign o_full       = (r_state != F_IDLE);
    assign o_qpush      = (r_state == F_PUSH) && !i_qstat.full;
    assign o_qdata.c_re = r_cre;
    assign o_qdata.c_im = r_cim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_offx  <= n_offx;
                        r_offy  <= n_offy;
                        r_state <= F_MRE;
                    end
                end
                F_MRE: begin
                    r_prod  <= n_prod;
                    r_state <= F_MIM;
                end
                F_MIM: begin
                    r_cre   <= prod_sat;
                    r_prod  <= n_prod;
                    r_state <= F_SAT;
                end
                F_SAT: begin
                    r_cim   <= prod_sat;
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_qstat.full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

[hdl/mei_queue.sv]
// Short queue of complex points between the front end and the iteration engine.
`timescale 1ns / 1ps

module mei_queue
    import mei_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cpoint i_data,
    input  logic    i_pop,
    output t_cpoint o_data,
    output t_qstat  o_stat
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_QW = $clog2(Q_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(Q_DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(Q_DEPTH);

    t_cpoint            r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_QW-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hdl/mei_back.sv]
// Iteration engine: runs z = z*z + c for one point and holds the finished result.
`timescale 1ns / 1ps

module mei_back
    import mei_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  t_qstat              i_qstat,
    input  t_cpoint             i_qdata,
    output logic                o_qpop,
    output logic                o_empty,
    input  logic                i_pop,
    output logic [CNT_W-1:0]    o_iterations,
    output logic                o_paint
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_ADD,
        B_FIN
    } t_bstate;

    t_bstate                    r_state;
    logic signed [FIX_W-1:0]    r_cre;
    logic signed [FIX_W-1:0]    r_cim;
    logic signed [FIX_W-1:0]    r_re;
    logic signed [FIX_W-1:0]    r_im;
    logic signed [2*FIX_W-1:0]  r_rr;
    logic signed [2*FIX_W-1:0]  r_ii;
    logic signed [2*FIX_W-1:0]  r_ri;
    logic [CNT_W-1:0]           r_count;
    logic                       r_ovalid;
    logic [CNT_W-1:0]           r_oiter;
    logic                       r_opaint;

    logic signed [WIDE_W-1:0]   diff;
    logic signed [WIDE_W-1:0]   n_re_wide;
    logic signed [WIDE_W-1:0]   n_im_wide;
    logic [2*FIX_W-1:0]         mag;
    logic                       escaped;
    logic                       out_free;

    // Both squares are non-negative, so their sum fits in 64 bits unsigned.
    assign mag     = $unsigned(r_rr) + $unsigned(r_ii);
    assign escaped = (mag > ESC_LIMIT);

    assign diff = $signed({{(WIDE_W-2*FIX_W){r_rr[2*FIX_W-1]}}, r_rr})
                - $signed({{(WIDE_W-2*FIX_W){r_ii[2*FIX_W-1]}}, r_ii});
    assign n_re_wide = (diff >>> 24)
                     + $signed({{(WIDE_W-FIX_W){r_cre[FIX_W-1]}}, r_cre});
    assign n_im_wide = ($signed({{(WIDE_W-2*FIX_W){r_ri[2*FIX_W-1]}}, r_ri}) >>> 23)
                     + $signed({{(WIDE_W-FIX_W){r_cim[FIX_W-1]}}, r_cim});

    assign out_free     = !r_ovalid || i_pop;
    assign o_qpop       = (r_state == B_IDLE) && !i_qstat.empty;
    assign o_empty      = !r_ovalid;
    assign o_iterations = r_oiter;
    assign o_paint      = r_opaint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // A new result replaces one that is popped in the same cycle.
            if ((r_state == B_FIN) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_pop && r_ovalid) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_cre   <= i_qdata.c_re;
                        r_cim   <= i_qdata.c_im;
                        r_re    <= '0;
                        r_im    <= '0;
                        r_count <= '0;
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_rr    <= r_re * r_re;
                    r_ii    <= r_im * r_im;
                    r_ri    <= r_re * r_im;
                    r_state <= B_ADD;
                end
                B_ADD: begin
                    // The squares of the current z double as its escape test.
                    if (escaped || (r_count == i_cfg.iter_limit)) begin
                        r_state <= B_FIN;
                    end else begin
                        r_re    <= sat32(n_re_wide);
                        r_im    <= sat32(n_im_wide);
                        r_count <= r_count + 1'b1;
                        r_state <= B_MUL;
                    end
                end
                B_FIN: begin
                    if (out_free) begin
                        r_oiter  <= r_count;
                        r_opaint <= (r_count < i_cfg.paint_threshold);
                        r_state  <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

[hdl/mandelbrot_escape_iterator.sv]
// Top level of the Mandelbrot escape-time iterator with its configuration registers.
`timescale 1ns / 1ps

// The block takes one pixel (column, row) per push transaction and returns one
// result transaction holding the escape count and the paint flag. The front end
// turns the pixel into the complex point c with a single shared multiplier and
// places it in a two-entry queue, so it can take the next pixel while the
// iteration engine is still busy. Each iteration of the engine passes through
// a multiply state for the three 32 by 32 products and an add state for the
// add, the saturation and the escape compare. The loop through the multipliers
// and the saturating adders of the engine sets the speed of the block. A
// finished result waits in an output register, and the engine goes on with the
// next point until a second result is ready while the first has not been popped.
// Configuration is to be written through the APB-style port only while no pixel
// is in flight; the block itself does not enforce this. Registers lie at byte
// addresses 0 (zoom), 4 (centre x), 8 (centre y), 12 (iteration limit) and 16
// (paint threshold).

module mandelbrot_escape_iterator
    import mei_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Pixel input.
    input  logic                push,
    output logic                full,
    input  logic [PIX_W-1:0]    i_column,
    input  logic [PIX_W-1:0]    i_row,
    // Result output.
    output logic                empty,
    input  logic                pop,
    output logic [CNT_W-1:0]    o_iterations,
    output logic                o_paint
);

    // Configuration registers.
    logic [ZOOM_W-1:0]          r_zoom;
    logic signed [CTR_W-1:0]    r_center_x;
    logic signed [CTR_W-1:0]    r_center_y;
    logic [CNT_W-1:0]           r_iter_limit;
    logic [CNT_W-1:0]           r_paint_thr;

    logic       cfg_wr;
    logic [2:0] cfg_idx;
    t_cfg       cfg;

    // Front to queue and queue to back.
    logic       q_push;
    t_cpoint    q_wdata;
    logic       q_pop;
    t_cpoint    q_rdata;
    t_qstat     q_stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom       <= 32'd65536;
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_iter_limit <= 16'd100;
            r_paint_thr  <= 16'd25;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ZOOM:       r_zoom       <= pwdata;
                REG_CENTER_X:   r_center_x   <= pwdata[CTR_W-1:0];
                REG_CENTER_Y:   r_center_y   <= pwdata[CTR_W-1:0];
                REG_ITER_LIMIT: r_iter_limit <= pwdata[CNT_W-1:0];
                REG_PAINT_THR:  r_paint_thr  <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back; the centre registers are returned sign-extended.
    always_comb begin
        case (cfg_idx)
            REG_ZOOM:       prdata = r_zoom;
            REG_CENTER_X:   prdata = {{(32-CTR_W){r_center_x[CTR_W-1]}}, r_center_x};
            REG_CENTER_Y:   prdata = {{(32-CTR_W){r_center_y[CTR_W-1]}}, r_center_y};
            REG_ITER_LIMIT: prdata = {{(32-CNT_W){1'b0}}, r_iter_limit};
            REG_PAINT_THR:  prdata = {{(32-CNT_W){1'b0}}, r_paint_thr};
            default:        prdata = '0;
        endcase
    end

    assign cfg.zoom            = r_zoom;
    assign cfg.center_x        = r_center_x;
    assign cfg.center_y        = r_center_y;
    assign cfg.iter_limit      = r_iter_limit;
    assign cfg.paint_threshold = r_paint_thr;

    mei_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_column   (i_column),
        .i_row      (i_row),
        .i_cfg      (cfg),
        .i_qstat    (q_stat),
        .o_qpush    (q_push),
        .o_qdata    (q_wdata)
    );

    mei_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_data     (q_wdata),
        .i_pop      (q_pop),
        .o_data     (q_rdata),
        .o_stat     (q_stat)
    );

    mei_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_qstat      (q_stat),
        .i_qdata      (q_rdata),
        .o_qpop       (q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_iterations (o_iterations),
        .o_paint      (o_paint)
    );

    // An accepted pixel keeps the front end busy in the following cycle.
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> full)
        else $error("front end took a pixel but did not go busy");

    // The front end only pushes a point when the queue has room.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("point pushed into a full queue");

    // The engine only takes a point when the queue holds one.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("point popped from an empty queue");

endmodule

[dv/mandelbrot_escape_iterator_tb.sv]
// Self-checking testbench of the Mandelbrot escape-time iterator, with its own pixel predictor.
`timescale 1ns / 1ps

// The testbench drives pixel push transactions into the block and pops result
// transactions out of it. It writes the view registers through the APB-style
// port only while nothing is in flight, and reads each one back. Every accepted
// pixel is run through a local escape-time predictor that uses a shadow copy of
// the registers. The predicted count and paint flag go into a queue, and a
// checker process compares each popped result with the oldest entry.
//
// The run goes through a list of named tests. The directed ones cover the reset
// view, iteration limits of zero, one and the maximum, zoom of zero and full
// scale, the centre extremes and the paint threshold boundaries. A back-pressure
// test holds the result side off for a long stretch so that the block fills up,
// and then lets the sender wait until every result has come. The random views
// follow, with idling bursts on both sides, and a final streaming part that runs
// without any idling.

module mandelbrot_escape_iterator_tb;
    import mei_pkg::*;

    // Generous bound on the run; the slowest correct run stays well below it.
    localparam longint      CYCLE_LIMIT   = 4_000_000;
    // Quiet cycles allowed after the last result before touching registers.
    localparam int          SETTLE_CYCLES = 20;
    localparam int          PRINT_LIMIT   = 40;
    localparam int          RANDOM_VIEWS  = 12;
    localparam int          VIEW_PIXELS   = 150;
    localparam int          STREAM_PIXELS = 200;
    // |z|^2 > 16 in Q.48.
    localparam logic [63:0] ESCAPE_BOUND  = 64'd16 << 48;
    localparam longint      Q_MAX         = 64'sd2147483647;
    localparam longint      Q_MIN         = -64'sd2147483648;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [4:0]          paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                push     = 1'b0;
    logic                full;
    logic [PIX_W-1:0]    i_column = '0;
    logic [PIX_W-1:0]    i_row    = '0;
    logic                empty;
    logic                pop      = 1'b0;
    logic [CNT_W-1:0]    o_iterations;
    logic                o_paint;

    // One predicted result, tagged with the pixel that caused it.
    typedef struct packed {
        logic [PIX_W-1:0] column;
        logic [PIX_W-1:0] row;
        logic [CNT_W-1:0] iterations;
        logic             paint;
    } t_escape;

    t_escape escape_q[$];
    t_escape escape_head;
    t_cfg    view_cfg;

    int      error_count      = 0;
    int      pixels_sent      = 0;
    int      results_checked  = 0;
    int      settings_applied = 0;
    longint  cycle_count      = 0;

    // Idling control shared by both sides; written with nonblocking assignments.
    bit      idling_on        = 1'b1;
    // A long result-side hold-off is ordered by bumping the serial number.
    int      hold_serial      = 0;
    int      hold_len         = 0;
    int      pop_hold_taken   = 0;
    int      pop_hold_left    = 0;
    int      pop_gap_left     = 0;

    mandelbrot_escape_iterator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .i_column     (i_column),
        .i_row        (i_row),
        .empty        (empty),
        .pop          (pop),
        .o_iterations (o_iterations),
        .o_paint      (o_paint)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Clamp to the signed 32-bit range of a Q8.24 value.
    function automatic longint clamp_q824(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // Escape count and paint flag of one pixel under the current view.
    function automatic t_escape predict_escape(input logic [PIX_W-1:0] col,
                                               input logic [PIX_W-1:0] row);
        longint          scale, ctr, off_re, off_im, c_re, c_im;
        longint          z_re, z_im, n_re, n_im;
        longint unsigned mag;
        int unsigned     count;
        t_escape         res;
        scale  = longint'(view_cfg.zoom);
        ctr    = longint'(view_cfg.center_x);
        off_re = longint'(col);
        off_re = off_re - FRAME_WIDTH / 2 + ctr;
        ctr    = longint'(view_cfg.center_y);
        off_im = longint'(row);
        off_im = off_im - FRAME_HEIGHT / 2 + ctr;
        c_re   = clamp_q824(off_re * scale);
        c_im   = clamp_q824(off_im * scale);
        z_re   = 0;
        z_im   = 0;
        count  = 0;
        while (count < view_cfg.iter_limit) begin
            // The shifts on signed values round towards minus infinity.
            n_re = clamp_q824(((z_re * z_re - z_im * z_im) >>> 24) + c_re);
            n_im = clamp_q824(((z_re * z_im) >>> 23) + c_im);
            z_re = n_re;
            z_im = n_im;
            count++;
            mag = z_re * z_re;
            mag = mag + z_im * z_im;
            if (mag > ESCAPE_BOUND) break;
        end
        res.column     = col;
        res.row        = row;
        res.iterations = count[CNT_W-1:0];
        res.paint      = (count < view_cfg.paint_threshold);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Reporting, timeout and result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
        error_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, escape_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Values are sampled just after the edge, so they are the ones the block
    // saw at that edge.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && empty === 1'b0) begin
            if (escape_q.size() == 0) begin
                report_mismatch($sformatf("result with none expected: iterations %0d paint %0b",
                                          o_iterations, o_paint));
            end else begin
                escape_head = escape_q.pop_front();
                results_checked++;
                if (o_iterations !== escape_head.iterations) begin
                    report_mismatch($sformatf("pixel (%0d,%0d) iterations %0d, expected %0d",
                                              escape_head.column, escape_head.row,
                                              o_iterations, escape_head.iterations));
                end
                if (o_paint !== escape_head.paint) begin
                    report_mismatch($sformatf("pixel (%0d,%0d) paint %0b, expected %0b",
                                              escape_head.column, escape_head.row,
                                              o_paint, escape_head.paint));
                end
            end
        end
    end

    // Result side: pops freely, idles in short random bursts while idling is
    // enabled, and takes a long hold-off whenever a test orders one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_hold_taken != hold_serial) begin
            pop_hold_taken = hold_serial;
            pop_hold_left  = hold_len;
            pop <= 1'b0;
        end else if (pop_hold_left != 0) begin
            pop_hold_left--;
            pop <= 1'b0;
        end else if (pop_gap_left != 0) begin
            pop_gap_left--;
            pop <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            pop_gap_left = $urandom_range(0, 7);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // All driver tasks are entered just after a rising edge. Push is left high
    // on return, so that a following transaction does not lower and raise it
    // within one time step.
    task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
        int gap;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push     <= 1'b1;
        i_column <= col;
        i_row    <= row;
        do @(posedge i_clk); while (full !== 1'b0);
        escape_q.push_back(predict_escape(col, row));
        pixels_sent++;
    endtask

    // Stop offering pixels and wait until every expected result has come.
    task automatic wait_drained();
        push <= 1'b0;
        while (escape_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Each APB transaction ends by lowering psel and penable, leaving the port idle.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [2:0] idx, output logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Read a register back and compare the bits it holds with the shadow copy.
    task automatic check_register(input logic [2:0] idx);
        logic [31:0] got, want, mask;
        case (idx)
            REG_ZOOM: begin
                want = view_cfg.zoom;
                mask = 32'hFFFF_FFFF;
            end
            REG_CENTER_X: begin
                want = {11'b0, view_cfg.center_x};
                mask = 32'h001F_FFFF;
            end
            REG_CENTER_Y: begin
                want = {11'b0, view_cfg.center_y};
                mask = 32'h001F_FFFF;
            end
            REG_ITER_LIMIT: begin
                want = {16'b0, view_cfg.iter_limit};
                mask = 32'h0000_FFFF;
            end
            REG_PAINT_THR: begin
                want = {16'b0, view_cfg.paint_threshold};
                mask = 32'h0000_FFFF;
            end
            default: begin
                want = '0;
                mask = '0;
            end
        endcase
        apb_read(idx, got);
        if ((got & mask) != (want & mask)) begin
            report_mismatch($sformatf("register %0d reads %h, expected %h",
                                      idx, got & mask, want & mask));
        end
    endtask

    task automatic set_register(input logic [2:0] idx, input logic [31:0] value);
        apb_write(idx, value);
        case (idx)
            REG_ZOOM:       view_cfg.zoom            = value;
            REG_CENTER_X:   view_cfg.center_x        = value[CTR_W-1:0];
            REG_CENTER_Y:   view_cfg.center_y        = value[CTR_W-1:0];
            REG_ITER_LIMIT: view_cfg.iter_limit      = value[CNT_W-1:0];
            REG_PAINT_THR:  view_cfg.paint_threshold = value[CNT_W-1:0];
            default: ;
        endcase
        check_register(idx);
    endtask

    // Registers change only once the block has gone quiet.
    task automatic apply_view(input logic [31:0] zoom, input logic [31:0] cx,
                              input logic [31:0] cy, input logic [31:0] limit,
                              input logic [31:0] threshold);
        wait_drained();
        set_register(REG_ZOOM, zoom);
        set_register(REG_CENTER_X, cx);
        set_register(REG_CENTER_Y, cy);
        set_register(REG_ITER_LIMIT, limit);
        set_register(REG_PAINT_THR, threshold);
        settings_applied++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values read back, then the centre, two corners and other pixels in the reset view.
    task automatic test_reset_view();
        check_register(REG_ZOOM);
        check_register(REG_CENTER_X);
        check_register(REG_CENTER_Y);
        check_register(REG_ITER_LIMIT);
        check_register(REG_PAINT_THR);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd512);
        send_pixel(10'd1023, 10'd512);
        send_pixel(10'd512, 10'd0);
        send_pixel(10'd300, 10'd700);
    endtask

    // A limit of zero runs no iteration at all; limits of one and two stop early.
    task automatic test_iteration_limits();
        apply_view(32'd65536, 32'd0, 32'd0, 32'd0, 32'd25);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd0, 10'd1023);
        apply_view(32'd65536, 32'd0, 32'd0, 32'd1, 32'd1);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd1023, 10'd1023);
        apply_view(32'd65536, 32'd0, 32'd0, 32'd2, 32'd2);
        send_pixel(10'd0, 10'd0);
    endtask

    // Zoom 0 pins c to 0; full-scale zoom saturates c, far centres do so only at a large zoom.
    task automatic test_zoom_and_centre();
        apply_view(32'd0, 32'hFFF0_0000, 32'h000F_FFFF, 32'd40, 32'd20);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        apply_view(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd40, 32'd20);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd513, 10'd512);
        apply_view(32'd1, 32'hFFF0_0000, 32'h000F_FFFF, 32'd30, 32'd10);
        send_pixel(10'd0, 10'd1023);
        apply_view(32'h0100_0000, 32'h000F_FFFF, 32'hFFF0_0000, 32'd30, 32'd10);
        send_pixel(10'd1023, 10'd0);
    endtask

    // Paint flag at threshold zero, the maximum, and exactly at the count.
    task automatic test_paint_threshold();
        apply_view(32'd65536, 32'd0, 32'd0, 32'd50, 32'd0);
        send_pixel(10'd1023, 10'd0);
        apply_view(32'd65536, 32'd0, 32'd0, 32'd50, 32'd65535);
        send_pixel(10'd512, 10'd512);
        apply_view(32'd65536, 32'd0, 32'd0, 32'd50, 32'd50);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd0, 10'd0);
    endtask

    // The highest limit: one point that never escapes and one that escapes after two iterations.
    task automatic test_longest_limit();
        apply_view(32'd65536, 32'd0, 32'd0, 32'd65535, 32'd65535);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd1023, 10'd0);
    endtask

    // The result side holds off for a long stretch while pixels keep coming, so
    // the block fills up and raises full; the sender then waits for the drain.
    task automatic test_backpressure();
        apply_view(32'd65536, 32'd0, 32'd0, 32'd6, 32'd3);
        idling_on   <= 1'b0;
        hold_len    <= 300;
        hold_serial <= hold_serial + 1;
        repeat (16) send_pixel(PIX_W'($urandom_range(0, 1023)),
                               PIX_W'($urandom_range(0, 1023)));
        idling_on   <= 1'b1;
        wait_drained();
    endtask

    // Random views, now and then at a register extreme, with random pixels.
    task automatic test_random_views();
        logic [31:0] zoom, cx, cy, limit, threshold;
        int          pick;
        for (int v = 0; v < RANDOM_VIEWS; v++) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       zoom = 32'h0;
                1:       zoom = 32'hFFFF_FFFF;
                2:       zoom = $urandom();
                default: zoom = $urandom_range(8192, 196608);
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0:       cx = 32'hFFF0_0000;
                1:       cx = 32'h000F_FFFF;
                2:       cx = $urandom();
                default: cx = $urandom_range(0, 800) - 400;
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0:       cy = 32'hFFF0_0000;
                1:       cy = 32'h000F_FFFF;
                2:       cy = $urandom();
                default: cy = $urandom_range(0, 800) - 400;
            endcase
            // Large limits are kept rare because each interior point costs
            // a pass through the multiply and the add state per iteration.
            pick = $urandom_range(0, 9);
            case (pick)
                0:       limit = 32'd0;
                1:       limit = 32'd1;
                2:       limit = $urandom_range(100, 200);
                default: limit = $urandom_range(2, 64);
            endcase
            if ($urandom_range(0, 4) == 0) begin
                threshold = $urandom() & 32'h0000_FFFF;
            end else begin
                threshold = $urandom_range(0, limit + 4);
            end
            apply_view(zoom, cx, cy, limit, threshold);
            repeat (VIEW_PIXELS) send_pixel(PIX_W'($urandom_range(0, 1023)),
                                            PIX_W'($urandom_range(0, 1023)));
        end
    endtask

    // The last part runs with both sides ready at every cycle.
    task automatic test_streaming();
        idling_on <= 1'b0;
        apply_view(32'd49152, 32'hFFFF_FF80, 32'd0, 32'd32, 32'd12);
        repeat (STREAM_PIXELS) send_pixel(PIX_W'($urandom_range(0, 1023)),
                                          PIX_W'($urandom_range(0, 1023)));
    endtask

    initial begin
        view_cfg.zoom            = 32'd65536;
        view_cfg.center_x        = '0;
        view_cfg.center_y        = '0;
        view_cfg.iter_limit      = 16'd100;
        view_cfg.paint_threshold = 16'd25;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_view();
        test_iteration_limits();
        test_zoom_and_centre();
        test_paint_threshold();
        test_longest_limit();
        test_backpressure();
        test_random_views();
        test_streaming();
        wait_drained();

        $display("covered %0d pixels with %0d checked results across %0d register settings,",
                 pixels_sent, results_checked, settings_applied);
        $display("including limits 0 and 65535, zoom 0 and full scale, far centres and a full stall");
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/mei_pkg.sv
hdl/mei_front.sv
hdl/mei_queue.sv
hdl/mei_back.sv
hdl/mandelbrot_escape_iterator.sv
dv/mandelbrot_escape_iterator_tb.sv
